### rtl/mbdf_pkg.sv
package mbdf_pkg;

  localparam int unsigned HDR_BYTES     = 6;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [15:0] MAX_LEN_RST   = 16'd300;
  localparam logic [7:0]  MAX_UNIT_RST  = 8'd247;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LEN  = 2'd0,
    CFG_MAX_UNIT = 2'd1
  } mbdf_cfg_idx_e;

  typedef enum logic [2:0] {
    EV_HEADER    = 3'd0,
    EV_FORWARD   = 3'd1,
    EV_DISCARD   = 3'd2,
    EV_REJECT    = 3'd3,
    EV_IGNORED   = 3'd4,
    EV_CLOSED    = 3'd5
  } mbdf_event_e;

  typedef struct packed {
    logic [15:0] max_payload_length;
    logic [7:0]  max_unit_address;
  } mbdf_cfg_t;

  typedef struct packed {
    mbdf_event_e event_res;
    logic [7:0]  payload_byte;
    logic        is_last;
    logic [15:0] transaction_id;
    logic [7:0]  unit_id;
    logic [15:0] frame_length;
  } mbdf_res_t;

endpackage

### rtl/mbdf_ifs.sv
interface mbdf_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface mbdf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  payload_byte;
  logic        is_last;
  logic [15:0] transaction_id;
  logic [7:0]  unit_id;
  logic [15:0] frame_length;

  modport source (output valid, output event_res, output payload_byte, output is_last,
                  output transaction_id, output unit_id, output frame_length, input ready);
  modport sink   (input valid, input event_res, input payload_byte, input is_last,
                  input transaction_id, input unit_id, input frame_length, output ready);
endinterface

interface mbdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/mbdf_cfg_regs.sv
module mbdf_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_i,
  input  logic [mbdf_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [mbdf_pkg::CFG_DATA_W-1:0] data_i,
  output mbdf_pkg::mbdf_cfg_t             cfg_o
);
  import mbdf_pkg::*;

  mbdf_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      unique case (idx_i)
        CFG_MAX_LEN:  cfg_d.max_payload_length = data_i[15:0];
        CFG_MAX_UNIT: cfg_d.max_unit_address   = data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload_length <= MAX_LEN_RST;
      cfg_q.max_unit_address   <= MAX_UNIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/mbdf_core.sv
module mbdf_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                op_i,
  input  logic [7:0]          data_byte_i,
  input  mbdf_pkg::mbdf_cfg_t cfg_i,
  output mbdf_pkg::mbdf_res_t res_o
);
  import mbdf_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_DROP    = 2'd2;

  localparam logic [2:0] HDR_LAST = 3'(HDR_BYTES - 1);

  logic [1:0]  phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] tid_q, tid_d;
  logic [15:0] pid_q, pid_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  unit_q, unit_d;
  logic        unit_ok_q, unit_ok_d;

  logic [2:0]  hdr_idx;
  logic [16:0] cnt_inc;
  mbdf_res_t   res;

  // a header count out of range restarts the header
  assign hdr_idx = (cnt_q >= 16'(HDR_BYTES)) ? 3'd0 : cnt_q[2:0];
  assign cnt_inc = {1'b0, cnt_q} + 17'd1;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    tid_d     = tid_q;
    pid_d     = pid_q;
    len_d     = len_q;
    unit_d    = unit_q;
    unit_ok_d = unit_ok_q;

    res                = '0;
    res.event_res      = EV_IGNORED;
    res.transaction_id = tid_q;
    res.frame_length   = len_q;

    if (op_i) begin
      phase_d   = PH_HEADER;
      cnt_d     = '0;
      tid_d     = '0;
      pid_d     = '0;
      len_d     = '0;
      unit_d    = '0;
      unit_ok_d = 1'b0;
      res                = '0;
      res.event_res      = EV_CLOSED;
    end else begin
      unique case (phase_q)
        PH_HEADER: begin
          unique case (hdr_idx)
            3'd0: begin
              tid_d = {data_byte_i, 8'h00};
              pid_d = '0;
              len_d = '0;
            end
            3'd1:    tid_d[7:0] = data_byte_i;
            3'd2:    pid_d      = {data_byte_i, 8'h00};
            3'd3:    pid_d[7:0] = data_byte_i;
            3'd4:    len_d      = {data_byte_i, 8'h00};
            default: len_d[7:0] = data_byte_i;
          endcase
          res.event_res = EV_HEADER;
          if (hdr_idx == HDR_LAST) begin
            cnt_d = '0;
            if (pid_d != 16'd0 || len_d == 16'd0 || len_d > cfg_i.max_payload_length) begin
              phase_d       = PH_DROP;
              res.event_res = EV_REJECT;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end else begin
            cnt_d = {13'd0, hdr_idx} + 16'd1;
          end
          res.transaction_id = tid_d;
          res.frame_length   = len_d;
        end
        PH_PAYLOAD: begin
          if (cnt_q == 16'd0) begin
            unit_d    = data_byte_i;
            unit_ok_d = (data_byte_i <= cfg_i.max_unit_address);
          end
          res.event_res    = unit_ok_d ? EV_FORWARD : EV_DISCARD;
          res.payload_byte = data_byte_i;
          res.unit_id      = unit_d;
          if (cnt_inc >= {1'b0, len_q}) begin
            res.is_last = 1'b1;
            phase_d     = PH_HEADER;
            cnt_d       = '0;
          end else begin
            cnt_d = cnt_inc[15:0];
          end
        end
        default: ;  // drop, and the spare code behaves the same
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      cnt_q     <= '0;
      tid_q     <= '0;
      pid_q     <= '0;
      len_q     <= '0;
      unit_q    <= '0;
      unit_ok_q <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      tid_q     <= tid_d;
      pid_q     <= pid_d;
      len_q     <= len_d;
      unit_q    <= unit_d;
      unit_ok_q <= unit_ok_d;
    end
  end

  assign res_o = res;

endmodule

### rtl/mbdf_skid.sv
module mbdf_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  mbdf_pkg::mbdf_res_t data_i,
  output logic                ready_o,
  output logic                valid_o,
  output mbdf_pkg::mbdf_res_t data_o,
  input  logic                ready_i
);
  import mbdf_pkg::*;

  logic      out_valid_q, skid_valid_q;
  mbdf_res_t out_q, skid_q;
  logic      push;

  assign ready_o = !skid_valid_q;
  assign push    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || ready_i) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (push) begin
      skid_q <= data_i;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

### rtl/mbap_request_deframer_top.sv
// Output: the result is valid in the cycle after acceptance when the output register is free;
// while out_o is stalled a result waits in the skid entry and then in the output register.
// Throughput: one request per cycle; the state update is a single pass over the header,
// payload and unit checks; the input closes only while both output entries are full.
// Reset (rst_ni low, asynchronous): frame state cleared, output stage emptied,
// max_payload_length back to 300 and max_unit_address back to 247.
module mbap_request_deframer_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  mbdf_in_if.sink    in_i,
  mbdf_out_if.source out_o,
  mbdf_cfg_if.sink   cfg_i
);
  import mbdf_pkg::*;

  mbdf_cfg_t cfg;
  mbdf_res_t res, res_out;
  logic      in_ready;
  logic      accept;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign accept      = in_i.valid && in_ready;

  mbdf_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_i.valid),
    .idx_i  (cfg_i.index),
    .data_i (cfg_i.data),
    .cfg_o  (cfg)
  );

  mbdf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (in_i.op),
    .data_byte_i (in_i.data_byte),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  mbdf_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .data_i  (res),
    .ready_o (in_ready),
    .valid_o (out_o.valid),
    .data_o  (res_out),
    .ready_i (out_o.ready)
  );

  assign out_o.event_res      = res_out.event_res;
  assign out_o.payload_byte   = res_out.payload_byte;
  assign out_o.is_last        = res_out.is_last;
  assign out_o.transaction_id = res_out.transaction_id;
  assign out_o.unit_id        = res_out.unit_id;
  assign out_o.frame_length   = res_out.frame_length;

endmodule

### rtl/mbdf_checker.sv
module mbdf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  event_res_i,
  input logic [7:0]  payload_byte_i,
  input logic        is_last_i,
  input logic [15:0] transaction_id_i,
  input logic [7:0]  unit_id_i,
  input logic [15:0] frame_length_i
);
  import mbdf_pkg::*;

  logic is_payload;
  assign is_payload = (event_res_i == EV_FORWARD) || (event_res_i == EV_DISCARD);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({event_res_i, payload_byte_i, is_last_i, transaction_id_i,
               unit_id_i, frame_length_i}))
    else $error("result changed while stalled");

  // an empty output stage shows a request's result in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && in_valid_i && in_ready_i |=> out_valid_i)
    else $error("result missing one cycle after request");

  a_non_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_payload |-> payload_byte_i == 8'd0 && !is_last_i && unit_id_i == 8'd0)
    else $error("payload fields set on a non-payload result");

  a_closed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_res_i == EV_CLOSED |-> transaction_id_i == 16'd0 &&
      frame_length_i == 16'd0)
    else $error("frame fields set on a close result");

endmodule

bind mbap_request_deframer_top mbdf_checker u_mbdf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .event_res_i      (out_o.event_res),
  .payload_byte_i   (out_o.payload_byte),
  .is_last_i        (out_o.is_last),
  .transaction_id_i (out_o.transaction_id),
  .unit_id_i        (out_o.unit_id),
  .frame_length_i   (out_o.frame_length)
);
